// ===== hw/rtl/ddc_pkg.sv =====
package ddc_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int EXT_COUNT_OFFSET = 126;
	localparam int CHECKSUM_OFFSET = 127;
	localparam int OFS_W = 7;

	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_ADDRESS = 2'd2;

	localparam logic [1:0] OUT_OK = 2'd0;
	localparam logic [1:0] OUT_SUM_ERR = 2'd1;
	localparam logic [1:0] OUT_NOT_READY = 2'd2;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_enable;
		logic       sda_level;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [6:0] byte_offset;
		logic [7:0] block_number;
		logic       done_res;
		logic [1:0] outcome;
		logic       address_nack;
		logic       busy_res;
	} result_t;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [15:0] ready_timeout;
		logic [6:0]  device_address;
	} cfg_t;

endpackage

// ===== hw/rtl/ddc_edid_reader.sv =====
// EDID reader over a DDC bus, one result word per input word.
// Input channel (in_valid/in_ready): each word is either a tick (kind 0)
// carrying the sampled SDA level, or a begin command (kind 1).
// Output channel (out_valid/out_ready): one word per input word with the
// SCL and SDA drive, any received EDID byte with its offset and block,
// the done pulse with its outcome, the sticky address NACK flag and busy.
// The result word is registered; throughput is one word per cycle while
// out_ready is high. The sequencer state advances once per word, and bus
// timing comes from counting ticks. A skid register lets the block accept
// one more word while a result waits. in_ready then stays low until the skid
// register empties, so each receiver stall also stalls the input side.
// Reset clears the sequencer to idle and loads the default registers:
// 1000 ticks per phase, 1000 ticks timeout and device address 80.
// Registers are written through cfg_we/cfg_index/cfg_data while idle:
// a rule for the user, which the block itself does not enforce.
module ddc_edid_reader
	import ddc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic        sda_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_drive,
	output logic        sda_enable,
	output logic        sda_level,
	output logic        byte_valid,
	output logic [7:0]  byte_value,
	output logic [6:0]  byte_offset,
	output logic [7:0]  block_number,
	output logic        done_res,
	output logic [1:0]  outcome,
	output logic        address_nack,
	output logic        busy_res
);

	cfg_t    cfg_q;
	result_t res;
	result_t out_q, skid_q;
	logic    skid_valid_q;
	logic    step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= 16'd1000;
			cfg_q.ready_timeout <= 16'd1000;
			cfg_q.device_address <= 7'd80;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				CFG_TIMEOUT: cfg_q.ready_timeout <= cfg_data;
				CFG_ADDRESS: cfg_q.device_address <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_valid_q;
	assign step = in_valid && in_ready;

	ddc_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .step(step),
		.kind(kind), .sda_sample(sda_sample), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid || out_ready) begin
				if (skid_valid_q) begin
					out_valid <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid <= step;
				end
			end else if (step) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (step && out_valid && !out_ready) begin
			skid_q <= res;
		end
	end

	assign scl_drive = out_q.scl_drive;
	assign sda_enable = out_q.sda_enable;
	assign sda_level = out_q.sda_level;
	assign byte_valid = out_q.byte_valid;
	assign byte_value = out_q.byte_value;
	assign byte_offset = out_q.byte_offset;
	assign block_number = out_q.block_number;
	assign done_res = out_q.done_res;
	assign outcome = out_q.outcome;
	assign address_nack = out_q.address_nack;
	assign busy_res = out_q.busy_res;

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid) else $error("skid full with output empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && skid_valid_q) |=> !in_ready)
		else $error("accepted word with no room");
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid) else $error("accepted word lost");

endmodule

// ===== hw/rtl/ddc_core.sv =====
module ddc_core
	import ddc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  logic    kind,
	input  logic    sda_sample,
	output result_t res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_READY, PH_RS1, PH_RS2, PH_ST1, PH_WB1, PH_WB2,
		PH_RB1, PH_RB2, PH_RB3, PH_SP1, PH_SP2, PH_SP3
	} phase_t;

	typedef enum logic [2:0] {
		STG_WADDR, STG_OFFSET, STG_RESTART, STG_RADDR, STG_READ
	} stage_t;

	phase_t      phase_q, phase_d;
	stage_t      stage_q, stage_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] delay_q, delay_d;
	logic [15:0] wait_q, wait_d;
	logic [6:0]  offset_q, offset_d;
	logic [7:0]  block_q, block_d;
	logic [7:0]  ext_q, ext_d;
	logic [7:0]  sum_q, sum_d;
	logic        started_q, started_d;
	logic        nack_q, nack_d;
	logic        fail_q, fail_d;

	logic [15:0] hp;
	logic        last;
	logic        wbit;
	logic        last_byte;
	logic [7:0]  sum_new;
	result_t     r;

	always_comb begin
		hp = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
		last = ({1'b0, delay_q} + 17'd1) >= {1'b0, hp};
		last_byte = (offset_q == OFS_W'(BLOCK_BYTES - 1)) && (block_q == ext_q);
		wbit = (stage_q == STG_READ) ? last_byte : shift_q[7];
		sum_new = sum_q + shift_q;

		phase_d = phase_q; stage_d = stage_q; bit_count_d = bit_count_q;
		shift_d = shift_q; delay_d = delay_q; wait_d = wait_q;
		offset_d = offset_q; block_d = block_q; ext_d = ext_q; sum_d = sum_q;
		started_d = started_q; nack_d = nack_q; fail_d = fail_q;
		r = '0;
		r.scl_drive = 1'b1;

		if (kind) begin
			phase_d = PH_READY; stage_d = STG_WADDR; bit_count_d = '0;
			shift_d = '0; delay_d = '0; wait_d = cfg.ready_timeout;
			offset_d = '0; block_d = '0; ext_d = '0; sum_d = '0;
			started_d = 1'b0; nack_d = 1'b0; fail_d = 1'b0;
		end else if (phase_q == PH_READY) begin
			if (wait_q != 16'd0 && sda_sample) begin
				stage_d = STG_WADDR;
				phase_d = started_q ? PH_RS1 : PH_ST1;
				delay_d = '0;
			end else if (wait_q <= 16'd1) begin
				wait_d = '0;
				phase_d = PH_IDLE;
				r.done_res = 1'b1;
				r.outcome = OUT_NOT_READY;
			end else begin
				wait_d = wait_q - 16'd1;
			end
		end else if (phase_q != PH_IDLE) begin
			unique case (phase_q)
				PH_RS1: begin r.scl_drive = 1'b0; r.sda_enable = 1'b1; r.sda_level = 1'b1; end
				PH_RS2: begin r.sda_enable = 1'b1; r.sda_level = 1'b1; end
				PH_ST1: r.sda_enable = 1'b1;
				PH_WB1: begin r.scl_drive = 1'b0; r.sda_enable = 1'b1; r.sda_level = wbit; end
				PH_WB2: begin r.sda_enable = 1'b1; r.sda_level = wbit; end
				PH_RB1: r.scl_drive = 1'b0;
				PH_SP1: begin r.scl_drive = 1'b0; r.sda_enable = 1'b1; end
				PH_SP2: r.sda_enable = 1'b1;
				default: ;
			endcase
			if (phase_q == PH_RB2 && last) begin
				if (stage_q == STG_READ) shift_d = {shift_q[6:0], sda_sample};
				else nack_d = nack_q | sda_sample;
			end
			if (!last) begin
				delay_d = delay_q + 16'd1;
			end else begin
				delay_d = '0;
				unique case (phase_q)
					PH_RS1: phase_d = PH_RS2;
					PH_RS2: phase_d = PH_ST1;
					PH_ST1: begin
						started_d = 1'b1;
						if (stage_q == STG_WADDR) begin
							shift_d = {cfg.device_address, 1'b0};
						end else begin
							stage_d = STG_RADDR;
							shift_d = {cfg.device_address, 1'b1};
						end
						bit_count_d = '0;
						phase_d = PH_WB1;
					end
					PH_WB1: phase_d = PH_WB2;
					PH_WB2: begin
						if (stage_q != STG_READ) begin
							if (bit_count_q < 4'd7) begin
								bit_count_d = bit_count_q + 4'd1;
								shift_d = {shift_q[6:0], 1'b0};
								phase_d = PH_WB1;
							end else begin
								phase_d = PH_RB1;
							end
						end else begin
							r.byte_valid = 1'b1;
							r.byte_value = shift_q;
							r.byte_offset = offset_q;
							r.block_number = block_q;
							sum_d = sum_new;
							if (block_q == 8'd0 && offset_q == OFS_W'(EXT_COUNT_OFFSET))
								ext_d = shift_q;
							bit_count_d = '0;
							shift_d = '0;
							if (offset_q == OFS_W'(CHECKSUM_OFFSET) && sum_new != 8'd0) begin
								fail_d = 1'b1;
								phase_d = PH_SP1;
							end else if (offset_q >= OFS_W'(BLOCK_BYTES - 1)) begin
								if (block_q == ext_d) begin
									phase_d = PH_SP1;
								end else begin
									block_d = block_q + 8'd1;
									offset_d = '0;
									sum_d = '0;
									phase_d = PH_RB1;
								end
							end else begin
								offset_d = offset_q + 7'd1;
								phase_d = PH_RB1;
							end
						end
					end
					PH_RB1: phase_d = PH_RB2;
					PH_RB2: phase_d = PH_RB3;
					PH_RB3: begin
						unique case (stage_q)
							STG_WADDR: begin
								stage_d = STG_OFFSET; shift_d = '0;
								bit_count_d = '0; phase_d = PH_WB1;
							end
							STG_OFFSET: begin
								stage_d = STG_RESTART;
								phase_d = started_q ? PH_RS1 : PH_ST1;
							end
							STG_RADDR: begin
								stage_d = STG_READ; shift_d = '0;
								bit_count_d = '0; phase_d = PH_RB1;
							end
							STG_READ: begin
								if (bit_count_q < 4'd7) begin
									bit_count_d = bit_count_q + 4'd1;
									phase_d = PH_RB1;
								end else begin
									phase_d = PH_WB1;
								end
							end
							default: phase_d = PH_IDLE;
						endcase
					end
					PH_SP1: phase_d = PH_SP2;
					PH_SP2: phase_d = PH_SP3;
					default: begin
						started_d = 1'b0;
						phase_d = PH_IDLE;
						r.done_res = 1'b1;
						r.outcome = fail_q ? OUT_SUM_ERR : OUT_OK;
					end
				endcase
			end
		end
		r.address_nack = nack_d;
		r.busy_res = (phase_d != PH_IDLE);
		res = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; stage_q <= STG_WADDR; bit_count_q <= '0;
			shift_q <= '0; delay_q <= '0; wait_q <= '0; offset_q <= '0;
			block_q <= '0; ext_q <= '0; sum_q <= '0; started_q <= 1'b0;
			nack_q <= 1'b0; fail_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; stage_q <= stage_d; bit_count_q <= bit_count_d;
			shift_q <= shift_d; delay_q <= delay_d; wait_q <= wait_d;
			offset_q <= offset_d; block_q <= block_d; ext_q <= ext_d;
			sum_q <= sum_d; started_q <= started_d; nack_q <= nack_d;
			fail_q <= fail_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && r.done_res) |-> !r.busy_res) else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && r.byte_valid) |-> (stage_q == STG_READ)) else $error("byte outside read");
	assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= 4'd7) else $error("bit count overflow");

endmodule

// ===== verif/ddc_edid_reader_tb.sv =====
`timescale 1ns / 100ps

module ddc_edid_reader_tb;
	import ddc_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_READY, PH_RS1, PH_RS2, PH_ST1, PH_WB1, PH_WB2,
		PH_RB1, PH_RB2, PH_RB3, PH_SP1, PH_SP2, PH_SP3
	} bus_phase_e;

	typedef enum logic [2:0] {
		STG_WADDR, STG_OFFSET, STG_RESTART, STG_RADDR, STG_READ
	} read_stage_e;

	class edid_scoreboard;
		logic [15:0] half_period;
		logic [15:0] timeout;
		logic [6:0] dev_addr;
		bus_phase_e ph;
		read_stage_e stg;
		int unsigned bit_cnt;
		logic [7:0] shifter;
		int unsigned dly;
		int unsigned wait_left;
		logic [6:0] ofs;
		logic [7:0] blk;
		logic [7:0] ext_total;
		logic [7:0] sum;
		bit started;
		bit nack;
		bit sum_bad;
		result_t expected_words[$];
		int errors;
		logic [7:0] eeprom[3][128];
		bit stuck_low;
		bit nack_slave;

		function new();
			half_period = 16'd1000;
			timeout = 16'd1000;
			dev_addr = 7'd80;
			errors = 0;
			stuck_low = 0;
			nack_slave = 0;
			clear_seq();
		endfunction

		function void clear_seq();
			ph = PH_IDLE;
			stg = STG_WADDR;
			bit_cnt = 0;
			shifter = '0;
			dly = 0;
			wait_left = 0;
			ofs = '0;
			blk = '0;
			ext_total = '0;
			sum = '0;
			started = 0;
			nack = 0;
			sum_bad = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_HALF_PERIOD: half_period = data;
				CFG_TIMEOUT: timeout = data;
				CFG_ADDRESS: dev_addr = data[6:0];
				default: ;
			endcase
		endfunction

		function void fill_eeprom(int ext, bit corrupt);
			logic [7:0] acc;
			int bad_blk;
			for (int b = 0; b < 3; b++) begin
				acc = '0;
				for (int i = 0; i < 127; i++) begin
					eeprom[b][i] = 8'($urandom_range(0, 255));
					if (b == 0 && i == EXT_COUNT_OFFSET)
						eeprom[b][i] = 8'(ext);
					acc = acc + eeprom[b][i];
				end
				eeprom[b][127] = -acc;
			end
			if (corrupt) begin
				bad_blk = $urandom_range(0, ext);
				eeprom[bad_blk][127] = eeprom[bad_blk][127] + 8'($urandom_range(1, 255));
			end
		endfunction

		// Level the slave puts on SDA for the next tick.
		function bit slave_sda();
			logic [7:0] b;
			if (ph == PH_READY)
				return stuck_low ? 1'b0 : ($urandom_range(0, 4) != 0);
			if (ph == PH_RB1 || ph == PH_RB2 || ph == PH_RB3) begin
				if (stg == STG_READ) begin
					b = eeprom[blk % 3][ofs];
					return b[7 - bit_cnt];
				end
				return nack_slave ? $urandom_range(0, 1) : 1'b0;
			end
			return $urandom_range(0, 1);
		endfunction

		function void note_word(bit k, bit sda);
			result_t r;
			int unsigned hp;
			bit wbit;
			bit last;
			bit oe;
			bit lvl;
			r = '0;
			r.scl_drive = 1'b1;
			oe = 0;
			lvl = 0;
			if (k) begin
				clear_seq();
				ph = PH_READY;
				wait_left = timeout;
			end else if (ph == PH_READY) begin
				if (wait_left != 0 && sda) begin
					stg = STG_WADDR;
					ph = started ? PH_RS1 : PH_ST1;
					dly = 0;
				end else if (wait_left <= 1) begin
					wait_left = 0;
					ph = PH_IDLE;
					r.done_res = 1'b1;
					r.outcome = OUT_NOT_READY;
				end else begin
					wait_left--;
				end
			end else if (ph != PH_IDLE) begin
				hp = (half_period == 0) ? 1 : half_period;
				wbit = (stg == STG_READ) ? (ofs == BLOCK_BYTES - 1 && blk == ext_total)
					: shifter[7];
				last = (dly + 1) >= hp;
				case (ph)
					PH_RS1: begin r.scl_drive = 0; oe = 1; lvl = 1; end
					PH_RS2: begin oe = 1; lvl = 1; end
					PH_ST1: begin oe = 1; lvl = 0; end
					PH_WB1: begin r.scl_drive = 0; oe = 1; lvl = wbit; end
					PH_WB2: begin oe = 1; lvl = wbit; end
					PH_RB1: r.scl_drive = 0;
					PH_SP1: begin r.scl_drive = 0; oe = 1; lvl = 0; end
					PH_SP2: begin oe = 1; lvl = 0; end
					default: ;
				endcase
				r.sda_enable = oe;
				r.sda_level = oe & lvl;
				if (ph == PH_RB2 && last) begin
					if (stg == STG_READ) shifter = {shifter[6:0], sda};
					else nack = nack | sda;
				end
				if (!last) begin
					dly++;
				end else begin
					dly = 0;
					case (ph)
						PH_RS1: ph = PH_RS2;
						PH_RS2: ph = PH_ST1;
						PH_ST1: begin
							started = 1;
							if (stg == STG_WADDR) begin
								shifter = {dev_addr, 1'b0};
							end else begin
								stg = STG_RADDR;
								shifter = {dev_addr, 1'b1};
							end
							bit_cnt = 0;
							ph = PH_WB1;
						end
						PH_WB1: ph = PH_WB2;
						PH_WB2: begin
							if (stg != STG_READ) begin
								if (bit_cnt < 7) begin
									bit_cnt++;
									shifter = shifter << 1;
									ph = PH_WB1;
								end else begin
									ph = PH_RB1;
								end
							end else begin
								r.byte_valid = 1;
								r.byte_value = shifter;
								r.byte_offset = ofs;
								r.block_number = blk;
								sum = sum + shifter;
								if (blk == 0 && ofs == EXT_COUNT_OFFSET)
									ext_total = shifter;
								bit_cnt = 0;
								shifter = '0;
								if (ofs == CHECKSUM_OFFSET && sum != 0) begin
									sum_bad = 1;
									ph = PH_SP1;
								end else if (ofs >= BLOCK_BYTES - 1) begin
									if (blk == ext_total) begin
										ph = PH_SP1;
									end else begin
										blk = blk + 1;
										ofs = '0;
										sum = '0;
										ph = PH_RB1;
									end
								end else begin
									ofs = ofs + 1;
									ph = PH_RB1;
								end
							end
						end
						PH_RB1: ph = PH_RB2;
						PH_RB2: ph = PH_RB3;
						PH_RB3: begin
							case (stg)
								STG_WADDR: begin
									stg = STG_OFFSET;
									shifter = '0;
									bit_cnt = 0;
									ph = PH_WB1;
								end
								STG_OFFSET: begin
									stg = STG_RESTART;
									ph = started ? PH_RS1 : PH_ST1;
								end
								STG_RADDR: begin
									stg = STG_READ;
									shifter = '0;
									bit_cnt = 0;
									ph = PH_RB1;
								end
								STG_READ: begin
									if (bit_cnt < 7) begin
										bit_cnt++;
										ph = PH_RB1;
									end else begin
										ph = PH_WB1;
									end
								end
								default: ph = PH_IDLE;
							endcase
						end
						PH_SP1: ph = PH_SP2;
						PH_SP2: ph = PH_SP3;
						default: begin
							started = 0;
							ph = PH_IDLE;
							r.done_res = 1;
							r.outcome = sum_bad ? OUT_SUM_ERR : OUT_OK;
						end
					endcase
				end
			end
			r.address_nack = nack;
			r.busy_res = (ph != PH_IDLE);
			expected_words.push_back(r);
		endfunction

		function void compare(string name, longint e, longint a);
			if (e != a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			end
		endfunction

		function void check_word(result_t got);
			result_t e;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				return;
			end
			e = expected_words.pop_front();
			compare("scl_drive", e.scl_drive, got.scl_drive);
			compare("sda_enable", e.sda_enable, got.sda_enable);
			compare("sda_level", e.sda_level, got.sda_level);
			compare("byte_valid", e.byte_valid, got.byte_valid);
			compare("byte_value", e.byte_value, got.byte_value);
			compare("byte_offset", e.byte_offset, got.byte_offset);
			compare("block_number", e.block_number, got.block_number);
			compare("done_res", e.done_res, got.done_res);
			compare("outcome", e.outcome, got.outcome);
			compare("address_nack", e.address_nack, got.address_nack);
			compare("busy_res", e.busy_res, got.busy_res);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic sda_sample;
	logic out_valid;
	logic out_ready;
	result_t res;
	edid_scoreboard sb;
	longint cycles;
	bit no_idle;
	int stall_left;

	ddc_edid_reader DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .sda_sample(sda_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_drive(res.scl_drive), .sda_enable(res.sda_enable),
		.sda_level(res.sda_level), .byte_valid(res.byte_valid),
		.byte_value(res.byte_value), .byte_offset(res.byte_offset),
		.block_number(res.block_number), .done_res(res.done_res),
		.outcome(res.outcome), .address_nack(res.address_nack),
		.busy_res(res.busy_res)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 75) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready)
			sb.check_word(res);
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= gap_len();
		end
	end

	task automatic send_word(input bit k, input bit s);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sda_sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(k, s);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One EDID read. A positive abort_at restarts the read after that many ticks.
	task automatic edid_read(input int ext, input bit corrupt, input int abort_at,
		input int tick_cap);
		int n;
		sb.fill_eeprom(ext, corrupt);
		send_word(1'b1, $urandom_range(0, 1));
		n = 0;
		while (sb.ph != PH_IDLE && n < tick_cap) begin
			if (n == abort_at)
				send_word(1'b1, $urandom_range(0, 1));
			else
				send_word(1'b0, sb.slave_sda());
			n++;
		end
	endtask

	initial begin
		int ext;
		cycles = 0;
		stall_left = 0;
		no_idle = 0;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HALF_PERIOD;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		sda_sample = 1'b0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(1'b0, 1'b1);
		send_word(1'b0, 1'b0);
		write_reg(CFG_TIMEOUT, 16'd0);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b1);
		write_reg(CFG_TIMEOUT, 16'd3);
		sb.stuck_low = 1;
		edid_read(0, 0, -1, 20);
		sb.stuck_low = 0;
		write_reg(CFG_TIMEOUT, 16'd65535);
		write_reg(CFG_HALF_PERIOD, 16'd65535);
		write_reg(CFG_ADDRESS, 16'd127);
		edid_read(0, 0, 6, 12);
		write_reg(CFG_HALF_PERIOD, 16'd0);
		write_reg(CFG_ADDRESS, 16'd0);
		sb.nack_slave = 1;
		edid_read(1, 0, -1, 300);
		sb.nack_slave = 0;
		write_reg(CFG_HALF_PERIOD, 16'd1);
		write_reg(CFG_TIMEOUT, 16'd1000);
		write_reg(CFG_ADDRESS, 16'd80);
		edid_read(0, 1, -1, 300);

		for (int i = 0; i < 14; i++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			write_reg(CFG_HALF_PERIOD,
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1));
			write_reg(CFG_ADDRESS, 16'($urandom_range(0, 127)));
			sb.stuck_low = ($urandom_range(0, 5) == 0);
			if (sb.stuck_low)
				write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 20)));
			else
				write_reg(CFG_TIMEOUT, 16'($urandom_range(20, 65535)));
			sb.nack_slave = ($urandom_range(0, 3) == 0);
			ext = $urandom_range(0, 2);
			edid_read(ext, $urandom_range(0, 3) == 0,
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : -1, 70);
		end
		sb.stuck_low = 0;
		no_idle = 0;

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
